// ===== sv/rvrp_pkg.sv =====
// shared types and constants of the read variant record packer
// used by every module of the block; no dependencies
package rvrp_pkg;

    localparam int POSITION_BITS_DEFAULT = 13;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    // longest run before it is closed on its own
    localparam logic [3:0] MAX_RUN = 4'd15;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_READ_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_MARGIN = 1'd1;

    localparam logic [12:0] READ_LENGTH_RESET = 13'd150;
    localparam logic [3:0]  EDGE_MARGIN_RESET = 4'd3;

    // change code kinds: below deletion is an inserted base, above a substitution
    localparam logic [2:0] KIND_DELETION = 3'd4;

    localparam logic [1:0] REC_SUBSTITUTION = 2'd0;
    localparam logic [1:0] REC_INSERTION    = 2'd1;
    localparam logic [1:0] REC_DELETION     = 2'd2;

    localparam int OUT_DATA_BITS = 32;

    // classification of one change code, made at the front
    typedef struct packed {
        logic [2:0] kind;
        logic       last;
        logic       in_window;   // position before the end margin
        logic       head_ok;     // position at or past the start margin
    } code_flags_t;

    localparam int FLAG_BITS = $bits(code_flags_t);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  run_length;
        logic [7:0]  bases;
        logic [14:0] shifted_pos;
        logic [2:0]  sub_code;
        logic        last;
    } record_t;

endpackage

// ===== sv/rvrp_front.sv =====
// front end: config registers and margin classification of change codes
// depends on rvrp_pkg
module rvrp_front #(
    parameter int POSITION_BITS = rvrp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rvrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rvrp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    input  logic [POSITION_BITS-1:0]           in_pos,
    input  logic [2:0]                         in_kind,
    input  logic                               in_last,
    input  logic                               queue_ready,
    output logic                               push,
    output logic [POSITION_BITS-1:0]           push_pos,
    output rvrp_pkg::code_flags_t              push_flags
);

    localparam int CMP_BITS = ((POSITION_BITS > 13) ? POSITION_BITS : 13) + 1;

    logic [12:0] read_length_reg;
    logic [3:0]  edge_margin_reg;

    logic [CMP_BITS-1:0] pos_ext;
    logic [CMP_BITS-1:0] margin_ext;
    logic [CMP_BITS-1:0] length_ext;
    logic [CMP_BITS-1:0] pos_plus_margin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_length_reg <= rvrp_pkg::READ_LENGTH_RESET;
            edge_margin_reg <= rvrp_pkg::EDGE_MARGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                rvrp_pkg::REG_READ_LENGTH: read_length_reg <= cfg_data[12:0];
                rvrp_pkg::REG_EDGE_MARGIN: edge_margin_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign pos_ext         = CMP_BITS'(in_pos);
    assign margin_ext      = CMP_BITS'(edge_margin_reg);
    assign length_ext      = CMP_BITS'(read_length_reg);
    // p < length - margin, kept unsigned
    assign pos_plus_margin = pos_ext + margin_ext;

    assign push     = in_valid && queue_ready;
    assign push_pos = in_pos;

    always_comb begin
        push_flags.kind      = in_kind;
        push_flags.last      = in_last;
        push_flags.in_window = pos_plus_margin < length_ext;
        push_flags.head_ok   = pos_ext >= margin_ext;
    end

endmodule

// ===== sv/rvrp_queue.sv =====
// short queue of classified change codes between front and back
// depends on rvrp_pkg for the default depth
module rvrp_queue #(
    parameter int WIDTH = 19,
    parameter int DEPTH = rvrp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             ready,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    assign ready      = count_reg != (AW + 1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== sv/rvrp_back.sv =====
// back end: pending run, indel offset and a two-entry record buffer
// depends on rvrp_pkg
module rvrp_back #(
    parameter int POSITION_BITS = rvrp_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     head_valid,
    input  logic [POSITION_BITS-1:0] head_pos,
    input  rvrp_pkg::code_flags_t    head_flags,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rvrp_pkg::record_t        out_rec
);

    function automatic logic [14:0] pos15(input logic [POSITION_BITS-1:0] p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[14:0];
    endfunction

    function automatic rvrp_pkg::record_t run_record(
        input logic                     ins,
        input logic [3:0]               count,
        input logic [7:0]               bases,
        input logic [POSITION_BITS-1:0] start,
        input logic [14:0]              offset
    );
        rvrp_pkg::record_t r;
        r.kind        = ins ? rvrp_pkg::REC_INSERTION : rvrp_pkg::REC_DELETION;
        r.run_length  = count;
        r.bases       = ins ? bases : 8'd0;
        r.shifted_pos = pos15(start) + offset;
        r.sub_code    = 3'd0;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic [14:0] offset_after(
        input logic        ins,
        input logic [3:0]  count,
        input logic [14:0] offset
    );
        return ins ? offset - 15'(count) : offset + 15'(count);
    endfunction

    // pending run
    logic                     open_reg,  open_next;
    logic                     ins_reg,   ins_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [3:0]               count_reg, count_next;
    logic [7:0]               bases_reg, bases_next;
    logic [14:0]              offset_reg, offset_next;

    // record buffer
    rvrp_pkg::record_t buf0_reg, buf0_next;
    rvrp_pkg::record_t buf1_reg, buf1_next;
    logic [1:0]        fill_reg, fill_next;

    rvrp_pkg::record_t rec0, rec1, rec_tmp;
    logic [1:0]        n_rec;
    logic              extends_run;
    logic              is_ins_code;
    logic [POSITION_BITS:0] run_end;
    logic [2:0]        free_slots;
    logic              drain;
    logic [1:0]        remain;

    assign is_ins_code = head_flags.kind < rvrp_pkg::KIND_DELETION;
    assign run_end     = {1'b0, start_reg} + (POSITION_BITS + 1)'(count_reg);

    always_comb begin
        if (!open_reg) begin
            extends_run = 1'b0;
        end else if (ins_reg) begin
            extends_run = is_ins_code && ({1'b0, head_pos} == run_end);
        end else begin
            extends_run = (head_flags.kind == rvrp_pkg::KIND_DELETION) &&
                          (head_pos == start_reg);
        end
    end

    always_comb begin
        open_next   = open_reg;
        ins_next    = ins_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        bases_next  = bases_reg;
        offset_next = offset_reg;
        rec0        = '0;
        rec1        = '0;
        rec_tmp     = '0;
        n_rec       = 2'd0;

        if (extends_run) begin
            if (ins_reg && count_reg < 4'd4) begin
                case (count_reg[1:0])
                    2'd0:    bases_next[7:6] = head_flags.kind[1:0];
                    2'd1:    bases_next[5:4] = head_flags.kind[1:0];
                    2'd2:    bases_next[3:2] = head_flags.kind[1:0];
                    default: bases_next[1:0] = head_flags.kind[1:0];
                endcase
            end
            count_next = count_reg + 1'b1;
            if (count_next >= rvrp_pkg::MAX_RUN) begin
                rec0        = run_record(ins_next, count_next, bases_next, start_next,
                                         offset_next);
                n_rec       = 2'd1;
                offset_next = offset_after(ins_next, count_next, offset_next);
                open_next   = 1'b0;
                ins_next    = 1'b0;
                start_next  = '0;
                count_next  = '0;
                bases_next  = '0;
            end
        end else if (head_flags.in_window) begin
            if (head_flags.kind > rvrp_pkg::KIND_DELETION) begin
                if (head_flags.head_ok) begin
                    if (open_next) begin
                        rec0        = run_record(ins_next, count_next, bases_next, start_next,
                                                 offset_next);
                        n_rec       = 2'd1;
                        offset_next = offset_after(ins_next, count_next, offset_next);
                        open_next   = 1'b0;
                        ins_next    = 1'b0;
                        start_next  = '0;
                        count_next  = '0;
                        bases_next  = '0;
                    end
                    rec_tmp.kind        = rvrp_pkg::REC_SUBSTITUTION;
                    rec_tmp.shifted_pos = pos15(head_pos) + offset_next;
                    rec_tmp.sub_code    = head_flags.kind;
                    if (n_rec == 2'd0) begin
                        rec0 = rec_tmp;
                    end else begin
                        rec1 = rec_tmp;
                    end
                    n_rec = n_rec + 1'b1;
                end
            end else begin
                if (open_next) begin
                    rec0        = run_record(ins_next, count_next, bases_next, start_next,
                                             offset_next);
                    n_rec       = 2'd1;
                    offset_next = offset_after(ins_next, count_next, offset_next);
                end
                open_next  = 1'b1;
                ins_next   = is_ins_code;
                start_next = head_pos;
                count_next = 4'd1;
                bases_next = is_ins_code ? {head_flags.kind[1:0], 6'd0} : 8'd0;
                // a limit of one closes the new run right away
                if (count_next >= rvrp_pkg::MAX_RUN) begin
                    rec_tmp = run_record(ins_next, count_next, bases_next, start_next,
                                         offset_next);
                    if (n_rec == 2'd0) begin
                        rec0 = rec_tmp;
                    end else begin
                        rec1 = rec_tmp;
                    end
                    n_rec       = n_rec + 1'b1;
                    offset_next = offset_after(ins_next, count_next, offset_next);
                    open_next   = 1'b0;
                    ins_next    = 1'b0;
                    start_next  = '0;
                    count_next  = '0;
                    bases_next  = '0;
                end
            end
        end

        if (head_flags.last) begin
            if (open_next) begin
                rec_tmp = run_record(ins_next, count_next, bases_next, start_next,
                                     offset_next);
                if (n_rec == 2'd0) begin
                    rec0 = rec_tmp;
                end else begin
                    rec1 = rec_tmp;
                end
                n_rec      = n_rec + 1'b1;
                open_next  = 1'b0;
                ins_next   = 1'b0;
                start_next = '0;
                count_next = '0;
                bases_next = '0;
            end
            offset_next = '0;
        end

        if (n_rec == 2'd2) begin
            rec1.last = 1'b1;
        end else if (n_rec == 2'd1) begin
            rec0.last = 1'b1;
        end
    end

    assign out_valid  = fill_reg != 2'd0;
    assign out_rec    = buf0_reg;
    assign drain      = out_valid && out_ready;
    assign remain     = fill_reg - {1'b0, drain};
    assign free_slots = 3'd2 - {1'b0, remain};
    assign pop        = head_valid && ({1'b0, n_rec} <= free_slots);

    always_comb begin
        buf0_next = drain ? buf1_reg : buf0_reg;
        buf1_next = buf1_reg;
        fill_next = remain;
        if (pop) begin
            fill_next = remain + n_rec;
            if (remain == 2'd0) begin
                buf0_next = rec0;
                buf1_next = rec1;
            end else if (remain == 2'd1) begin
                buf1_next = rec0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            ins_reg    <= 1'b0;
            start_reg  <= '0;
            count_reg  <= '0;
            bases_reg  <= '0;
            offset_reg <= '0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (pop) begin
                open_reg   <= open_next;
                ins_reg    <= ins_next;
                start_reg  <= start_next;
                count_reg  <= count_next;
                bases_reg  <= bases_next;
                offset_reg <= offset_next;
            end
        end
    end

endmodule

// ===== sv/read_variant_record_packer_top.sv =====
// path: a record reaches the m_ side through the queue slot and then the record buffer,
// which it enters only when the buffer has room
// throughput: one change code per cycle while the queue and the record buffer have room;
// a code that causes two records needs an empty record buffer, so a second such code waits
// reset: aresetn low at a clock edge clears the pending run, the indel offset, the queue
// and the record buffer, and sets read_length to 150 and edge_margin to 3
module read_variant_record_packer_top #(
    parameter int POSITION_BITS = rvrp_pkg::POSITION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH   = rvrp_pkg::QUEUE_DEPTH_DEFAULT,
    localparam int S_DATA_BITS  = ((POSITION_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rvrp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rvrp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_DATA_BITS-1:0]              s_tdata,   // code_position
    input  logic [2:0]                          s_tuser,   // code_kind
    input  logic                                s_tlast,   // read_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // run_length, inserted_bases, shifted_position, substitution_code
    output logic [rvrp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    output logic [1:0]                          m_tuser,   // record_kind
    output logic                                m_tlast    // group_last
);

    localparam int ENTRY_BITS = POSITION_BITS + rvrp_pkg::FLAG_BITS;

    logic                     push;
    logic [POSITION_BITS-1:0] push_pos;
    rvrp_pkg::code_flags_t    push_flags;
    logic                     queue_ready;
    logic                     pop;
    logic                     head_valid;
    logic [ENTRY_BITS-1:0]    head_data;
    rvrp_pkg::code_flags_t    head_flags;
    rvrp_pkg::record_t        out_rec;

    rvrp_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_pos     (s_tdata[POSITION_BITS-1:0]),
        .in_kind    (s_tuser),
        .in_last    (s_tlast),
        .queue_ready(queue_ready),
        .push       (push),
        .push_pos   (push_pos),
        .push_flags (push_flags)
    );

    rvrp_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_pos, push_flags}),
        .ready     (queue_ready),
        .pop       (pop),
        .head_valid(head_valid),
        .head_data (head_data)
    );

    assign head_flags = head_data[rvrp_pkg::FLAG_BITS-1:0];

    rvrp_back #(
        .POSITION_BITS(POSITION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_pos  (head_data[ENTRY_BITS-1:rvrp_pkg::FLAG_BITS]),
        .head_flags(head_flags),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign s_tready = queue_ready;
    assign m_tdata  = {2'b00, out_rec.sub_code, out_rec.shifted_pos, out_rec.bases,
                       out_rec.run_length};
    assign m_tuser  = out_rec.kind;
    assign m_tlast  = out_rec.last;

endmodule
